// ===== src/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg
// shared constants and pipeline stage types of the glyph pixel compositor
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int unsigned PixW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WtW     = 16;  // ws, wd and the blend divisor
  localparam int unsigned NumW    = 24;  // channel numerator, max 255 * 65025
  localparam int unsigned NumChan = 3;   // color channels, alpha done apart
  localparam int unsigned QBits   = 8;   // quotient bits, one per divider stage

  localparam logic [ByteW-1:0] AlphaOpaque = 8'hff;
  localparam logic [ByteW-1:0] AlphaClear  = 8'h00;
  // floor(x / 255) == (x * 0x8081) >> 23 for every 16-bit x
  localparam logic [WtW-1:0]   Recip255    = 16'h8081;
  localparam int unsigned      Recip255Sh  = 23;

  // after source selection
  typedef struct packed {
    logic            valid;
    logic            we;
    logic            blend;
    logic [PixW-1:0] pix;
    logic [PixW-1:0] src;
    logic [PixW-1:0] dst;
  } sel_t;

  // after the weight products
  typedef struct packed {
    logic                              valid;
    logic                              we;
    logic                              blend;
    logic [PixW-1:0]                   pix;
    logic [NumChan-1:0][ByteW-1:0]     cs;
    logic [NumChan-1:0][ByteW-1:0]     cd;
    logic [WtW-1:0]                    ws;
    logic [WtW-1:0]                    wd;
  } wgt_t;

  // after divisor and numerators
  typedef struct packed {
    logic                          valid;
    logic                          we;
    logic                          blend;
    logic [PixW-1:0]               pix;
    logic [WtW-1:0]                den;
    logic [NumChan-1:0][NumW-1:0]  num;
  } num_t;

  // one restoring divider stage
  typedef struct packed {
    logic                          valid;
    logic                          we;
    logic                          blend;
    logic [PixW-1:0]               pix;
    logic [WtW-1:0]                den;
    logic [ByteW-1:0]              alpha;
    logic [NumChan-1:0][NumW-1:0]  rem;
    logic [NumChan-1:0][QBits-1:0] quo;
  } div_t;

endpackage

// ===== src/glyph_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// glyph_pixel_compositor
// per-pixel glyph compositor with chroma key and integer alpha-over blend
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the output is not stalled, set by a
//   fully pipelined datapath with an eight-stage restoring divider (one
//   quotient bit per stage, three channels)
// a stalled output holds the whole pipeline; no bubble is ever lost
// reset clears all valid bits and sets the background key to zero
// ----------------------------------------------------------------------------
module glyph_pixel_compositor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write: background key
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gpc_pkg::PixW-1:0]       cfg_data_i,
  // input pixels
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // atlas_pixel, frame_pixel, fg_color, bg_color (lowest first)
  input  logic [4*gpc_pkg::PixW-1:0]     s_axis_tdata,
  // result
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gpc_pkg::PixW-1:0]       m_axis_tdata,  // out_pixel
  output logic                           m_axis_tuser   // write_enable
);
  import gpc_pkg::*;

  logic [PixW-1:0] bg_key_q;
  logic            pipe_en;

  sel_t sel_d, sel_q;
  wgt_t wgt_d, wgt_q;
  num_t num_d, num_q;
  div_t div_d [QBits+1];
  div_t div_q [QBits+1];

  // input fields
  logic [PixW-1:0] atlas, frame, fg, bg, rgba, src;
  logic            is_key;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_key_q <= '0;
    end else if (cfg_valid_i) begin
      bg_key_q <= cfg_data_i;
    end
  end

  // global stall: everything moves unless the output holds an untaken result
  assign pipe_en       = !div_q[QBits].valid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // stage 1: key compare and source / destination selection
  always_comb begin
    atlas  = s_axis_tdata[0*PixW +: PixW];
    frame  = s_axis_tdata[1*PixW +: PixW];
    fg     = s_axis_tdata[2*PixW +: PixW];
    bg     = s_axis_tdata[3*PixW +: PixW];
    rgba   = {atlas[PixW-ByteW-1:0], atlas[PixW-1 -: ByteW]};
    is_key = (atlas == bg_key_q);
    src    = is_key ? bg : fg;

    sel_d.valid = s_axis_tvalid;
    sel_d.we    = 1'b1;
    sel_d.blend = 1'b0;
    sel_d.src   = src;
    sel_d.dst   = is_key ? frame : rgba;
    sel_d.pix   = src;
    if (src[ByteW-1:0] == AlphaOpaque) begin
      sel_d.pix = src;
    end else if (src[ByteW-1:0] == AlphaClear) begin
      if (is_key) begin
        sel_d.we  = 1'b0;
        sel_d.pix = '0;
      end else begin
        sel_d.pix = rgba;
      end
    end else begin
      sel_d.blend = 1'b1;
    end
  end

  // stage 2: source and destination weights
  always_comb begin
    wgt_d.valid = sel_q.valid;
    wgt_d.we    = sel_q.we;
    wgt_d.blend = sel_q.blend;
    wgt_d.pix   = sel_q.pix;
    for (int c = 0; c < NumChan; c++) begin
      wgt_d.cs[c] = sel_q.src[(c+1)*ByteW +: ByteW];
      wgt_d.cd[c] = sel_q.dst[(c+1)*ByteW +: ByteW];
    end
    wgt_d.ws = {sel_q.src[ByteW-1:0], {ByteW{1'b0}}} - WtW'(sel_q.src[ByteW-1:0]);
    wgt_d.wd = WtW'(sel_q.dst[ByteW-1:0])
             * WtW'(AlphaOpaque - sel_q.src[ByteW-1:0]);
  end

  // stage 3: divisor and channel numerators
  always_comb begin
    num_d.valid = wgt_q.valid;
    num_d.we    = wgt_q.we;
    num_d.blend = wgt_q.blend;
    num_d.pix   = wgt_q.pix;
    num_d.den   = wgt_q.ws + wgt_q.wd;
    for (int c = 0; c < NumChan; c++) begin
      num_d.num[c] = NumW'(wgt_q.cs[c]) * NumW'(wgt_q.ws)
                   + NumW'(wgt_q.cd[c]) * NumW'(wgt_q.wd);
    end
  end

  // divider entry: output alpha by reciprocal, then one quotient bit a stage
  always_comb begin
    logic [2*WtW-1:0] prod;
    logic [NumW-1:0]  dsh;
    prod = (2*WtW)'(num_q.den) * (2*WtW)'(Recip255);

    div_d[0].valid = num_q.valid;
    div_d[0].we    = num_q.we;
    div_d[0].blend = num_q.blend;
    div_d[0].pix   = num_q.pix;
    div_d[0].den   = num_q.den;
    div_d[0].alpha = prod[Recip255Sh +: ByteW];
    div_d[0].rem   = num_q.num;
    div_d[0].quo   = '0;

    for (int i = 0; i < QBits; i++) begin
      div_d[i+1] = div_q[i];
      dsh = NumW'(div_q[i].den) << (QBits - 1 - i);
      for (int c = 0; c < NumChan; c++) begin
        if (div_q[i].rem[c] >= dsh) begin
          div_d[i+1].rem[c] = div_q[i].rem[c] - dsh;
          div_d[i+1].quo[c][QBits-1-i] = 1'b1;
        end
      end
    end
  end

  // valid bits are reset, payload is only loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q.valid <= 1'b0;
      wgt_q.valid <= 1'b0;
      num_q.valid <= 1'b0;
      for (int i = 0; i <= QBits; i++) begin
        div_q[i].valid <= 1'b0;
      end
    end else if (pipe_en) begin
      sel_q <= sel_d;
      wgt_q <= wgt_d;
      num_q <= num_d;
      for (int i = 0; i <= QBits; i++) begin
        div_q[i] <= div_d[i];
      end
    end
  end

  assign m_axis_tvalid = div_q[QBits].valid;
  assign m_axis_tuser  = div_q[QBits].we;
  assign m_axis_tdata  = div_q[QBits].blend
                       ? {div_q[QBits].quo[2], div_q[QBits].quo[1],
                          div_q[QBits].quo[0], div_q[QBits].alpha}
                       : div_q[QBits].pix;

endmodule

// ===== tb/gpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpc_checker
// watches the config, pixel and result channels of the glyph pixel
// compositor, predicts each result from the accepted pixels and the key it
// has seen written, and compares every result transaction in order
// ----------------------------------------------------------------------------
module gpc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [gpc_pkg::PixW-1:0]       cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // atlas_pixel, frame_pixel, fg_color, bg_color (lowest first)
  input  logic [4*gpc_pkg::PixW-1:0]     s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [gpc_pkg::PixW-1:0]       m_axis_tdata,  // out_pixel
  input  logic                           m_axis_tuser,  // write_enable
  output int                             fail_count_o,
  output int                             pending_o
);

  import gpc_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            we;
  } dest_write_t;

  logic [PixW-1:0] key_q;
  dest_write_t     dest_writes_q[$];
  int              fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = dest_writes_q.size();

  // integer alpha-over of src onto dst, both rgba, src alpha never zero
  function automatic logic [PixW-1:0] alpha_over(logic [PixW-1:0] src,
                                                 logic [PixW-1:0] dst);
    int unsigned a_s, a_d, w_s, w_d, den, c;
    logic [PixW-1:0] res;
    a_s = {24'h0, src[7:0]};
    a_d = {24'h0, dst[7:0]};
    w_s = a_s * 255;
    w_d = a_d * (255 - a_s);
    den = w_s + w_d;
    res = '0;
    res[7:0] = 8'(den / 255);
    for (int ch = 1; ch < 4; ch++) begin
      c = ({24'h0, src[ch*8 +: 8]} * w_s + {24'h0, dst[ch*8 +: 8]} * w_d) / den;
      res[ch*8 +: 8] = c[7:0];
    end
    return res;
  endfunction

  function automatic dest_write_t compose_pixel(logic [PixW-1:0] atlas,
                                                logic [PixW-1:0] frame,
                                                logic [PixW-1:0] fg,
                                                logic [PixW-1:0] bg,
                                                logic [PixW-1:0] key);
    dest_write_t     r;
    logic [PixW-1:0] atlas_rgba;
    r.pix = '0;
    r.we  = 1'b1;
    atlas_rgba = {atlas[23:0], atlas[31:24]};
    if (atlas == key) begin
      if (bg[7:0] == AlphaOpaque) r.pix = bg;
      else if (bg[7:0] == AlphaClear) r.we = 1'b0;
      else r.pix = alpha_over(bg, frame);
    end else begin
      if (fg[7:0] == AlphaOpaque) r.pix = fg;
      else if (fg[7:0] == AlphaClear) r.pix = atlas_rgba;
      else r.pix = alpha_over(fg, atlas_rgba);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dest_write_t want;
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        key_q <= cfg_data_i;
      end
      // check results before queueing new ones so an early result is caught
      if (m_axis_tvalid && m_axis_tready) begin
        if (dest_writes_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result pix=%08h we=%0b", $realtime,
                     m_axis_tdata, m_axis_tuser);
        end else begin
          want = dest_writes_q.pop_front();
          if (want.pix !== m_axis_tdata || want.we !== m_axis_tuser) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch pix exp=%08h got=%08h we exp=%0b got=%0b",
                       $realtime, want.pix, m_axis_tdata, want.we, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        dest_writes_q.push_back(compose_pixel(s_axis_tdata[31:0],
                                              s_axis_tdata[63:32],
                                              s_axis_tdata[95:64],
                                              s_axis_tdata[127:96], key_q));
      end
    end
  end

  initial fail_count = 0;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the glyph pixel compositor: directed key, glyph and blend
// corners, then random pixels over several background keys and stall patterns
// ----------------------------------------------------------------------------
module tb;

  import gpc_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [PixW-1:0]        cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // atlas_pixel, frame_pixel, fg_color, bg_color (lowest first)
  logic [4*PixW-1:0]      s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [PixW-1:0]        m_axis_tdata;  // out_pixel
  logic                   m_axis_tuser;  // write_enable

  int                     fail_count;
  int                     pending;
  int unsigned            send_idle_pct;
  int unsigned            recv_idle_pct;
  logic [PixW-1:0]        key;

  glyph_pixel_compositor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gpc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_pixel(logic [PixW-1:0] atlas, logic [PixW-1:0] frame,
                            logic [PixW-1:0] fg, logic [PixW-1:0] bg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bg, fg, frame, atlas};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_key(logic [PixW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    key = value;
  endtask

  // alpha corners are favored, the rest are random bytes
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(5))
      0: return AlphaClear;
      1: return AlphaOpaque;
      2: return 8'h01;
      3: return 8'hfe;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [PixW-1:0] atlas, frame, fg, bg, r;
    r = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: atlas = key;
      4: atlas = 32'h0;
      5: atlas = 32'hffffffff;
      default: atlas = $urandom();
    endcase
    if (atlas != key && r[0]) atlas ^= 32'h1;
    frame = {24'($urandom_range(32'h00ffffff, 0)), pick_alpha()};
    fg    = {24'($urandom_range(32'h00ffffff, 0)), pick_alpha()};
    bg    = {24'($urandom_range(32'h00ffffff, 0)), pick_alpha()};
    send_pixel(atlas, frame, fg, bg);
  endtask

  initial begin
    logic [PixW-1:0] keys[6];
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 87;
    key           = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // key still at its reset value of zero
    send_pixel(32'h0, 32'h89abcdef, 32'h11223344, 32'h123456ff);
    send_pixel(32'h0, 32'h89abcdef, 32'h11223344, 32'habcdef00);
    send_pixel(32'h0, 32'h55aa5500, 32'h11223344, 32'hffffff01);
    send_pixel(32'h0, 32'hffffffff, 32'h11223344, 32'h000000fe);
    send_pixel(32'h0, 32'h00000000, 32'h11223344, 32'hffffff80);
    send_pixel(32'h0, 32'h00000000, 32'h11223344, 32'h00000001);
    send_pixel(32'hffffffff, 32'h12345678, 32'hc0ffeeff, 32'h0);
    send_pixel(32'h80ff0000, 32'h12345678, 32'hffffff00, 32'h0);
    send_pixel(32'hffffffff, 32'h12345678, 32'hffffff01, 32'h0);
    send_pixel(32'h00000001, 32'h12345678, 32'h000000fe, 32'h0);
    send_pixel(32'h01020304, 32'h12345678, 32'hff00ff7f, 32'h0);
    send_pixel(32'h00ffffff, 32'h0, 32'h000000fe, 32'hffffffff);
    // nonzero key: zero atlas is now a glyph pixel
    write_key(32'hdeadbeef);
    send_pixel(32'hdeadbeef, 32'h12345678, 32'h0, 32'h876543ff);
    send_pixel(32'h00000000, 32'h12345678, 32'h0, 32'h876543ff);
    send_pixel(32'hdeadbeef, 32'hffffffff, 32'h0, 32'hffffff00);

    keys[0] = 32'hffffffff;
    keys[1] = $urandom();
    keys[2] = 32'h00000000;
    keys[3] = $urandom();
    keys[4] = 32'h80000000;
    keys[5] = $urandom();
    for (int ph = 0; ph < 6; ph++) begin
      write_key(keys[ph]);
      if (ph == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 17;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 150; n++) begin
        // hold off until the pipeline has drained once
        if (ph == 3 && n == 75) begin
          s_axis_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        send_random_pixel();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
